/* design/column_matrix_vector_product_defines.svh */
// Assertion macros for the column product design file.
// The clock is clk and the active-low reset is rst_n in every file that uses them.
`ifndef COLUMN_MATRIX_VECTOR_PRODUCT_DEFINES_SVH
`define COLUMN_MATRIX_VECTOR_PRODUCT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define CMVP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmvp assertion failed");

// Next-cycle implication.
`define CMVP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmvp assertion failed");

`else

`define CMVP_ASSERT_IMP(lbl, ante, cons)
`define CMVP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* design/cmvp_pkg.sv */
package cmvp_pkg;

    // Store geometry.
    localparam int MAX_DIM   = 64;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
    localparam int MAT_AW    = 2 * DIM_W;

    // Field widths.
    localparam int DATA_W = 32;
    localparam int SIZE_W = 7;
    localparam int FUNC_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

    // Request function codes.
    localparam logic [FUNC_W-1:0] FUNC_VEC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MAT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RUN = 2'd2;

    typedef logic [DATA_W-1:0] word_t;

endpackage

/* design/column_matrix_vector_product.sv */
// Transposed matrix-vector multiply. Requests with func 0 and 1 load one vector or matrix
// entry each and are taken one per cycle while no compute runs. A func 2 request emits,
// for each column c below the configured size n (size_in_use, saturated to 64), the wrapping
// 32-bit sum over rows of matrix[r][c] * vector[r], columns in order, the final one marked
// by last. The compute walks both stores through their single read ports, one element per
// cycle: each column has a start step, n reads, then the multiply and accumulate stages,
// and starts only once the output register is free; a compute holds the input off until
// its final column is done. A compute with size zero emits nothing. Entries
// must be written before a compute reads them. size_in_use may only be written while the
// block is idle.
`include "column_matrix_vector_product_defines.svh"

module column_matrix_vector_product
    import cmvp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [SIZE_W-1:0]        cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [FUNC_W-1:0]        func,
    input  logic [DIM_W-1:0]         row,
    input  logic [DIM_W-1:0]         col,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [DIM_W-1:0]         column_index,
    output logic signed [DATA_W-1:0] dot_sum,
    output logic                     last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_ISSUE = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [DIM_W-1:0]  r_reg, r_next;
    logic [DIM_W-1:0]  c_reg, c_next;
    logic [DIM_W-1:0]  nlast_reg, nlast_next;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_eff;

    logic accept;
    logic vec_we, mat_we, run_req;
    logic issue;
    logic out_free;
    logic col_done;

    word_t mat_rdata, vec_rdata;
    logic [2*DATA_W-1:0] prod_full;
    word_t prod_reg;
    word_t acc_reg;
    word_t acc_sum;

    logic v1_reg, first1_reg, last1_reg;
    logic v2_reg, first2_reg, last2_reg;

    logic             out_valid_reg;
    logic [DIM_W-1:0] out_col_reg;
    word_t            out_sum_reg;
    logic             out_last_reg;

    // Requests are taken only between computes.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // Request decode.
    always_comb
    begin
        vec_we  = 1'b0;
        mat_we  = 1'b0;
        run_req = 1'b0;
        unique case (func)
            FUNC_VEC: vec_we  = accept;
            FUNC_MAT: mat_we  = accept;
            FUNC_RUN: run_req = accept;
            default:  ;
        endcase
    end

    // Size in use, saturated to the store dimension.
    assign size_eff = (size_reg > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_reg;

    assign issue    = (state_reg == ST_ISSUE);
    assign out_free = !out_valid_reg || !out_stall;
    assign col_done = v2_reg && last2_reg;

    // Matrix store, addressed by row then column.
    cmvp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAT_DEPTH)
    ) u_mat_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr ({row, col}),
        .wdata (value),
        .re    (issue),
        .raddr ({r_reg, c_reg}),
        .rdata (mat_rdata)
    );

    // Vector store.
    cmvp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_DIM)
    ) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .waddr (row),
        .wdata (value),
        .re    (issue),
        .raddr (r_reg),
        .rdata (vec_rdata)
    );

    // Sequencer: wait for a free output, read one column, drain the pipeline.
    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        nlast_next = nlast_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (run_req && (size_eff != '0))
                begin
                    nlast_next = DIM_W'(size_eff - 1'b1);
                    c_next     = '0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (out_free)
                begin
                    r_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                r_next = r_reg + 1'b1;
                if (r_reg == nlast_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (col_done)
                begin
                    if (c_reg == nlast_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        c_next     = c_reg + 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Multiply and accumulate; the low 32 bits wrap the same for signed and unsigned.
    assign prod_full = mat_rdata * vec_rdata;
    assign acc_sum   = (first2_reg ? '0 : acc_reg) + prod_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            nlast_reg     <= '0;
            size_reg      <= SIZE_RESET;
            v1_reg        <= 1'b0;
            first1_reg    <= 1'b0;
            last1_reg     <= 1'b0;
            v2_reg        <= 1'b0;
            first2_reg    <= 1'b0;
            last2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            r_reg      <= r_next;
            c_reg      <= c_next;
            nlast_reg  <= nlast_next;
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
            v1_reg     <= issue;
            first1_reg <= (r_reg == '0);
            last1_reg  <= (r_reg == nlast_reg);
            v2_reg     <= v1_reg;
            first2_reg <= first1_reg;
            last2_reg  <= last1_reg;
            if (col_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= prod_full[DATA_W-1:0];
        end
        if (v2_reg)
        begin
            acc_reg <= acc_sum;
        end
        if (col_done)
        begin
            out_col_reg  <= c_reg;
            out_sum_reg  <= acc_sum;
            out_last_reg <= (c_reg == nlast_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign column_index = out_col_reg;
    assign dot_sum      = out_sum_reg;
    assign last         = out_last_reg;

    // A finished column never overwrites a result that is still waiting.
    `CMVP_ASSERT_IMP(a_no_overwrite, col_done, out_free)
    // Store writes and compute reads never share a cycle.
    `CMVP_ASSERT_IMP(a_no_write_in_run, mat_we || vec_we, !issue)
    // A column starts with an empty pipeline.
    `CMVP_ASSERT_IMP(a_start_empty, state_reg == ST_START, !v1_reg && !v2_reg)
    // The marked result ends the compute.
    `CMVP_ASSERT_NEXT(a_last_ends, col_done && (c_reg == nlast_reg), state_reg == ST_IDLE)

endmodule

/* design/cmvp_ram.sv */
module cmvp_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* tb/sv/column_matrix_vector_product_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the column product block. It keeps its own copy of
// the matrix, the vector and the size register, and it predicts the column sums
// of every accepted compute request. Each result is compared with the oldest
// prediction.
module column_matrix_vector_product_checker
    import cmvp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [SIZE_W-1:0]        cfg_wr_data,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [FUNC_W-1:0]        func,
    input  logic [DIM_W-1:0]         row,
    input  logic [DIM_W-1:0]         col,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [DIM_W-1:0]         column_index,
    input  logic signed [DATA_W-1:0] dot_sum,
    input  logic                     last,
    output int                       mismatch_count,
    output int                       pending_columns
);

    // Only the first mismatches are printed; all of them are counted.
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [DIM_W-1:0] column_index;
        word_t            dot_sum;
        logic             last;
    } column_sum_t;

    word_t             matrix_copy [MAT_DEPTH];
    word_t             vector_copy [MAX_DIM];
    logic [SIZE_W-1:0] size_copy;
    column_sum_t       column_sums_due [$];

    task automatic report_mismatch(string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Works out one sum per column below the size in use. The size saturates
    // at the store dimension, and products and sums wrap at 32 bits.
    task automatic predict_column_sums();
        int          dim;
        word_t       acc;
        column_sum_t sum;
        dim = (size_copy > MAX_DIM) ? MAX_DIM : int'(size_copy);
        for (int c = 0; c < dim; c++)
        begin
            acc = '0;
            for (int r = 0; r < dim; r++)
                acc += matrix_copy[r * MAX_DIM + c] * vector_copy[r];
            sum.column_index = DIM_W'(c);
            sum.dot_sum = acc;
            sum.last = (c == dim - 1);
            column_sums_due.push_back(sum);
        end
    endtask

    // Updates the copies on every accepted request and configuration write,
    // then checks every accepted result.
    always @(posedge clk or negedge rst_n)
    begin : track_and_compare
        column_sum_t want;
        if (!rst_n)
        begin
            size_copy = SIZE_RESET;
            column_sums_due.delete();
            mismatch_count = 0;
            pending_columns <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                size_copy = cfg_wr_data;

            if (in_valid && !in_stall)
            begin
                case (func)
                    FUNC_VEC: vector_copy[row] = value;
                    FUNC_MAT: matrix_copy[row * MAX_DIM + col] = value;
                    FUNC_RUN: predict_column_sums();
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (column_sums_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result for column %0d, sum %h",
                                              column_index, dot_sum));
                end
                else
                begin
                    want = column_sums_due.pop_front();
                    if (column_index !== want.column_index)
                        report_mismatch($sformatf("column_index %0d, expected %0d",
                                                  column_index, want.column_index));
                    if (dot_sum !== want.dot_sum)
                        report_mismatch($sformatf("column %0d: dot_sum %h, expected %h",
                                                  want.column_index, dot_sum, want.dot_sum));
                    if (last !== want.last)
                        report_mismatch($sformatf("column %0d: last %b, expected %b",
                                                  want.column_index, last, want.last));
                end
            end

            pending_columns <= column_sums_due.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import cmvp_pkg::*;

    // The one function code that the block ignores.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS  = 100;
    localparam int MAX_GAP          = 13;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_CYCLES     = 80;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 5000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0]        cfg_wr_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [FUNC_W-1:0]        func = FUNC_VEC;
    logic [DIM_W-1:0]         row = '0;
    logic [DIM_W-1:0]         col = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [DIM_W-1:0]         column_index;
    logic signed [DATA_W-1:0] dot_sum;
    logic                     last;
    int                       mismatch_count;
    int                       pending_columns;

    // Entries written so far; a compute only covers entries that hold data.
    bit matrix_loaded [MAX_DIM][MAX_DIM];
    bit vector_loaded [MAX_DIM];

    bit tx_burst;
    bit rx_burst;
    bit hold_request;
    int requests_sent;
    int quiet_cycles;

    column_matrix_vector_product dut (.*);

    column_matrix_vector_product_checker product_check (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic word_t random_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // Mostly an index inside the active square, sometimes anywhere in the store.
    function automatic int pick_index(int dim);
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, MAX_DIM - 1);
        return $urandom_range(0, dim - 1);
    endfunction

    // Offers one request after a random gap, none in a burst, and holds it until it is taken.
    task automatic send_request(logic [FUNC_W-1:0] f, int r, int c, word_t v);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        row <= DIM_W'(r);
        col <= DIM_W'(c);
        value <= v;
        do @(posedge clk); while (in_stall);
        requests_sent++;
        if (f == FUNC_VEC)
            vector_loaded[r] = 1'b1;
        else if (f == FUNC_MAT)
            matrix_loaded[r][c] = 1'b1;
    endtask

    // Waits until every predicted result has arrived and the block has settled.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_columns != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(int dim);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= SIZE_W'(dim);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Writes every vector and matrix entry of the active square that has not been written yet.
    task automatic fill_region(int dim);
        for (int r = 0; r < dim; r++)
        begin
            if (!vector_loaded[r])
                send_request(FUNC_VEC, r, $urandom_range(0, MAX_DIM - 1), random_word());
            for (int c = 0; c < dim; c++)
                if (!matrix_loaded[r][c])
                    send_request(FUNC_MAT, r, c, random_word());
        end
    endtask

    // Result side: a random stall before each result, bursts without stalls,
    // and one long hold when the stimulus asks for it.
    initial
    begin : result_sink
        int hold;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 25 == 0)
                rx_burst = ($urandom_range(0, 2) == 0);
            if (hold_request)
            begin
                hold = LONG_HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
            begin
                hold = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    // Ends the run when neither channel nor the register port moves for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int dim;
        int pick;
        int phase;
        int random_goal;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Size one with the most negative value times minus one, then the
        // largest positive values, and an ignored request between computes.
        set_size(1);
        send_request(FUNC_VEC, 0, 0, 32'h8000_0000);
        send_request(FUNC_MAT, 0, 0, 32'hFFFF_FFFF);
        send_request(FUNC_RUN, 0, 0, 32'h0000_0000);
        send_request(FUNC_MAT, 0, 0, 32'h7FFF_FFFF);
        send_request(FUNC_VEC, 0, 0, 32'h7FFF_FFFF);
        send_request(FUNC_UNUSED, MAX_DIM - 1, MAX_DIM - 1, 32'hFFFF_FFFF);
        send_request(FUNC_RUN, MAX_DIM - 1, MAX_DIM - 1, 32'hFFFF_FFFF);

        // A compute with size zero emits nothing.
        set_size(0);
        send_request(FUNC_RUN, 0, 0, 32'h0000_0000);

        // Size two, with writes at the far corner of the stores as well.
        set_size(2);
        send_request(FUNC_VEC, 1, 0, 32'hFFFF_FFFF);
        send_request(FUNC_MAT, 0, 1, 32'h0000_0000);
        send_request(FUNC_MAT, 1, 0, 32'h0000_0001);
        send_request(FUNC_MAT, 1, 1, 32'h8000_0000);
        send_request(FUNC_MAT, MAX_DIM - 1, MAX_DIM - 1, 32'h5555_5555);
        send_request(FUNC_VEC, MAX_DIM - 1, 0, 32'hAAAA_AAAA);
        send_request(FUNC_RUN, 0, 0, 32'h0000_0000);

        // Random phases: a small size, the missing entries of its square, then
        // a mix of loads, ignored requests and computes. The first phase sends a compute
        // right after its fill and holds the result side off so that the block backs
        // up while further requests wait.
        random_goal = requests_sent + RANDOM_REQUESTS;
        phase = 0;
        while (requests_sent < random_goal)
        begin
            if (phase == 0)
                dim = 5;
            else if ($urandom_range(0, 4) == 0)
                dim = $urandom_range(7, 10);
            else
                dim = $urandom_range(1, 6);
            tx_burst = ($urandom_range(0, 3) == 0);
            set_size(dim);
            if (phase == 0)
                hold_request = 1'b1;
            fill_region(dim);
            if (phase == 0)
                send_request(FUNC_RUN, 0, 0, 32'h0000_0000);
            repeat ($urandom_range(6, 14))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    send_request(FUNC_MAT, pick_index(dim), pick_index(dim), random_word());
                else if (pick < 45)
                    send_request(FUNC_VEC, pick_index(dim), $urandom_range(0, MAX_DIM - 1),
                                 random_word());
                else if (pick < 55)
                    send_request(FUNC_UNUSED, $urandom_range(0, MAX_DIM - 1),
                                 $urandom_range(0, MAX_DIM - 1), $urandom());
                else
                    send_request(FUNC_RUN, $urandom_range(0, MAX_DIM - 1),
                                 $urandom_range(0, MAX_DIM - 1), $urandom());
            end
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
